[rtl/swr_pkg.sv]
// Shared types, widths and codes for the sliding-window receiver.
package swr_pkg;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned WSIZE_W    = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SLOT_OUT_W = 12;
  localparam int unsigned SIZE_W     = 23;
  localparam int unsigned SLOTS_W    = 13;
  // Consumed slots plus a distance inside the window.
  localparam int unsigned SLOT_W     = 14;

  localparam logic [SLOTS_W-1:0] SLOTS_MAX = '1;
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE      = 2'd0,
    CFG_SELECTIVE_MODE   = 2'd1,
    CFG_INITIAL_SEQUENCE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RX_GOOD  = 2'd0,
    RX_BAD   = 2'd1,
    RX_FATAL = 2'd2
  } rx_status_e;

endpackage

[rtl/swr_if.sv]
// Valid/ready channel interfaces for packet headers and receiver results.
interface swr_pkt_if;
  import swr_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        receive_status;
  logic [SEQ_W-1:0]  sequence_number;
  logic              fin_flag;
  logic              other_flags;
  logic [LEN_W-1:0]  payload_length;

  modport source (output valid, receive_status, sequence_number, fin_flag, other_flags,
                  payload_length, input ready);
  modport sink   (input valid, receive_status, sequence_number, fin_flag, other_flags,
                  payload_length, output ready);
endinterface

interface swr_res_if;
  import swr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  send_ack;
  logic [SEQ_W-1:0]      ack_number;
  logic                  store_payload;
  logic [SLOT_OUT_W-1:0] buffer_slot;
  logic                  overflow;
  logic [SIZE_W-1:0]     file_size;
  logic                  finished;

  modport source (output valid, send_ack, ack_number, store_payload, buffer_slot, overflow,
                  file_size, finished, input ready);
  modport sink   (input valid, send_ack, ack_number, store_payload, buffer_slot, overflow,
                  file_size, finished, output ready);
endinterface

[rtl/sliding_window_receiver.sv]
// Top level of the sliding-window data-phase receiver.
//
//  Channel   Direction  Carries
//  pkt_i     in         one received packet header per transaction
//  res_o     out        ack, buffer placement, file size and finish flag per transaction
//  cfg_*     in         register writes: window size, mode, initial sequence
//
// Each header is captured in the input register and resolved from there into the
// result register, so one transaction is taken per cycle while the result register
// is empty or its result is accepted; the result is offered from the result register.
// Window base, bitmap, slot count and file size are updated together when a header
// is resolved, and the next header sees that updated state.
// While a result waits unaccepted, the input register still takes one header;
// the input stalls only once both registers are full. Reset is asynchronous
// and clears all control state, the bitmap, the counters and the
// configuration to their defaults.
module sliding_window_receiver import swr_pkg::*; #(
  parameter int unsigned MAX_WINDOW    = 32,
  parameter int unsigned PAYLOAD_BYTES = 1024,
  parameter int unsigned BUFFER_SLOTS  = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  swr_pkt_if.sink               pkt_i,
  swr_res_if.source             res_o
);

  localparam int unsigned IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned RunW = $clog2(MAX_WINDOW + 1);

  // Configuration registers.
  logic [WSIZE_W-1:0] win_size_q;
  logic               sel_mode_q;

  // Protocol state.
  logic [SEQ_W-1:0]   base_q, base_d;
  logic [SLOTS_W-1:0] slots_q, slots_d;
  logic [SIZE_W-1:0]  bytes_q, bytes_d;
  logic               done_q, done_d;

  // Input register.
  logic               in_vld_q;
  logic [1:0]         h_status_q;
  logic [SEQ_W-1:0]   h_seq_q;
  logic               h_fin_q;
  logic               h_other_q;
  logic [LEN_W-1:0]   h_len_q;

  // Result register.
  logic                  res_vld_q;
  logic                  ack_q, ack_d;
  logic [SEQ_W-1:0]      ackno_q, ackno_d;
  logic                  store_q, store_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic                  ovf_q, ovf_d;
  logic [SIZE_W-1:0]     size_q;
  logic                  fin_q;

  logic advance, proc_en;

  assign advance     = !res_vld_q || res_o.ready;
  assign proc_en     = in_vld_q && advance;
  assign pkt_i.ready = !in_vld_q || advance;

  // Effective window: zero counts as one, and the bitmap depth caps it.
  logic [RunW-1:0] eff_win;
  always_comb begin
    if (win_size_q == '0) begin
      eff_win = RunW'(1);
    end else if (32'(win_size_q) > 32'(MAX_WINDOW)) begin
      eff_win = RunW'(MAX_WINDOW);
    end else begin
      eff_win = RunW'(win_size_q);
    end
  end

  logic [LEN_W-1:0]  len_sat;
  logic [SEQ_W-1:0]  back, ahead;
  logic              is_good, ends, live, data_ok;
  logic              gbn_hit, in_prev, in_win, place_en, fits, mark_upd;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       byte_end;
  logic [SIZE_W-1:0] end_sat;
  logic [RunW-1:0]   run;
  logic [SLOT_W-1:0] slot_sum;

  assign len_sat = (32'(h_len_q) > 32'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : h_len_q;

  // Sequence distances wrap modulo 2^32.
  assign back  = base_q - h_seq_q;
  assign ahead = h_seq_q - base_q;

  assign is_good = (h_status_q == RX_GOOD);
  assign ends    = (h_status_q == RX_FATAL) || (is_good && h_fin_q);
  assign live    = !done_q;
  assign data_ok = live && !ends && is_good && !h_other_q;

  assign gbn_hit = (h_seq_q == base_q);
  // A packet from the previous window is only re-acknowledged.
  assign in_prev = (back != '0) && (back <= 32'(eff_win));
  assign in_win  = !in_prev && (ahead < 32'(eff_win));

  assign place_en = data_ok && (sel_mode_q ? in_win : gbn_hit);
  assign mark_upd = data_ok && sel_mode_q && in_win;

  assign slot = sel_mode_q ? (SLOT_W'(ahead[IdxW-1:0]) + SLOT_W'(slots_q)) : SLOT_W'(slots_q);
  assign fits = (32'(slot) < 32'(BUFFER_SLOTS));

  // Byte end of this payload in the reassembled file.
  assign byte_end = 32'(slot) * 32'(PAYLOAD_BYTES) + 32'(len_sat);
  assign end_sat  = (byte_end > 32'(SIZE_MAX)) ? SIZE_MAX : byte_end[SIZE_W-1:0];

  swr_marks #(
    .MaxWindow (MAX_WINDOW)
  ) u_swr_marks (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (proc_en && mark_upd),
    .idx_i  (ahead[IdxW-1:0]),
    .win_i  (eff_win),
    .run_o  (run)
  );

  always_comb begin
    base_d   = base_q;
    slot_sum = SLOT_W'(slots_q);
    if (place_en && !sel_mode_q) begin
      base_d   = base_q + 32'd1;
      slot_sum = SLOT_W'(slots_q) + SLOT_W'(1);
    end else if (mark_upd) begin
      base_d   = base_q + 32'(run);
      slot_sum = SLOT_W'(slots_q) + SLOT_W'(run);
    end
    slots_d = (slot_sum > SLOT_W'(SLOTS_MAX)) ? SLOTS_MAX : slot_sum[SLOTS_W-1:0];

    store_d = place_en && fits;
    ovf_d   = place_en && !fits;
    slot_d  = store_d ? slot[SLOT_OUT_W-1:0] : '0;
    bytes_d = (store_d && (end_sat > bytes_q)) ? end_sat : bytes_q;

    ack_d   = data_ok && (!sel_mode_q || in_prev || in_win);
    ackno_d = !ack_d ? '0 : (sel_mode_q ? h_seq_q : base_d);

    done_d  = done_q || (live && ends);
  end

  // Configuration writes and protocol state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WSIZE_W'(4);
      sel_mode_q <= 1'b0;
      base_q     <= '0;
      slots_q    <= '0;
      bytes_q    <= '0;
      done_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_SIZE:      win_size_q <= cfg_data_i[WSIZE_W-1:0];
        CFG_SELECTIVE_MODE:   sel_mode_q <= cfg_data_i[0];
        CFG_INITIAL_SEQUENCE: base_q     <= cfg_data_i[SEQ_W-1:0];
        default: ;
      endcase
    end else if (proc_en) begin
      base_q  <= base_d;
      slots_q <= slots_d;
      bytes_q <= bytes_d;
      done_q  <= done_d;
    end
  end

  // Input and result register valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (pkt_i.ready) begin
        in_vld_q <= pkt_i.valid;
      end
      if (proc_en) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pkt_i.valid && pkt_i.ready) begin
      h_status_q <= pkt_i.receive_status;
      h_seq_q    <= pkt_i.sequence_number;
      h_fin_q    <= pkt_i.fin_flag;
      h_other_q  <= pkt_i.other_flags;
      h_len_q    <= pkt_i.payload_length;
    end
    if (proc_en) begin
      ack_q   <= ack_d;
      ackno_q <= ackno_d;
      store_q <= store_d;
      slot_q  <= slot_d;
      ovf_q   <= ovf_d;
      size_q  <= bytes_d;
      fin_q   <= done_d;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.send_ack      = ack_q;
  assign res_o.ack_number    = ackno_q;
  assign res_o.store_payload = store_q;
  assign res_o.buffer_slot   = slot_q;
  assign res_o.overflow      = ovf_q;
  assign res_o.file_size     = size_q;
  assign res_o.finished      = fin_q;

endmodule

[rtl/swr_marks.sv]
// Received-packet bitmap with leading-run encoder and window slide.
module swr_marks import swr_pkg::*; #(
  parameter int unsigned MaxWindow = 32,
  localparam int unsigned IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1,
  localparam int unsigned RunW = $clog2(MaxWindow + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic [RunW-1:0] win_i,
  output logic [RunW-1:0] run_o
);

  logic [MaxWindow-1:0] marks_q;
  logic [MaxWindow-1:0] set_vec;
  logic [RunW-1:0]      run;

  always_comb begin
    for (int i = 0; i < MaxWindow; i++) begin
      set_vec[i] = marks_q[i] | (upd_i && (idx_i == IdxW'(i)));
    end
  end

  // Priority encode the first position that is unmarked or outside the window.
  always_comb begin
    run = RunW'(MaxWindow);
    for (int i = MaxWindow - 1; i >= 0; i--) begin
      if (!set_vec[i] || (RunW'(i) >= win_i)) begin
        run = RunW'(i);
      end
    end
  end

  assign run_o = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
    end else if (upd_i) begin
      marks_q <= set_vec >> run;
    end
  end

endmodule

[rtl/swr_checker.sv]
// Port-level checks on the receiver results, bound to the top level.
module swr_checker import swr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic                  send_ack_i,
  input logic [SEQ_W-1:0]      ack_number_i,
  input logic                  store_payload_i,
  input logic [SLOT_OUT_W-1:0] buffer_slot_i,
  input logic                  overflow_i,
  input logic [SIZE_W-1:0]     file_size_i,
  input logic                  finished_i
);

  logic              done_seen_q;
  logic [SIZE_W-1:0] last_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
      last_size_q <= '0;
    end else if (res_valid_i && res_ready_i) begin
      done_seen_q <= done_seen_q || finished_i;
      last_size_q <= file_size_i;
    end
  end

  // Unused result fields read as zero.
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> ((send_ack_i || ack_number_i == '0) &&
                     (store_payload_i || buffer_slot_i == '0)))
    else $error("ack number or buffer slot set without its flag");

  a_store_xor_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !(store_payload_i && overflow_i))
    else $error("payload both stored and flagged as overflow");

  a_finish_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && done_seen_q) |-> (finished_i && !send_ack_i && !store_payload_i))
    else $error("activity after the data phase ended");

  a_size_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (file_size_i >= last_size_q))
    else $error("file size went backwards");

endmodule

bind sliding_window_receiver swr_checker u_swr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .send_ack_i      (res_o.send_ack),
  .ack_number_i    (res_o.ack_number),
  .store_payload_i (res_o.store_payload),
  .buffer_slot_i   (res_o.buffer_slot),
  .overflow_i      (res_o.overflow),
  .file_size_i     (res_o.file_size),
  .finished_i      (res_o.finished)
);
